### rtl/core/hpt_pkg.sv
// shared types, constants and helpers for the homogeneous point transform
package hpt_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int NUM_W      = DATA_W + FRAC_W;
	localparam int DIV_STAGES = NUM_W;
	localparam int NUM_REGS   = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int REG_W      = 64;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int SUM_W      = PROD_W + 3;
	localparam int FLOOR_W    = SUM_W - FRAC_W;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 8'd7;

	localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_W;
	localparam logic [REG_W-1:0] ONE_HI = REG_W'(1) << (FRAC_W + 32);

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic               kind;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} hpt_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               divided;
		logic               saturated;
	} hpt_out_t;

	// per-item data that rides alongside the divider lanes
	typedef struct packed {
		logic                     do_div;
		logic                     sat;
		logic [2:0]               qneg;
		logic signed [DATA_W-1:0] vx;
		logic signed [DATA_W-1:0] vy;
		logic signed [DATA_W-1:0] vz;
	} hpt_side_t;

	typedef struct packed {
		logic                     sat;
		logic signed [DATA_W-1:0] val;
	} hpt_clamp_t;

	function automatic hpt_clamp_t clamp_floor(input logic signed [FLOOR_W-1:0] v);
		hpt_clamp_t r;
		r.sat = 1'b0;
		r.val = v[DATA_W-1:0];
		if (v > FLOOR_W'(DATA_MAX)) begin
			r.sat = 1'b1;
			r.val = DATA_MAX;
		end else if (v < FLOOR_W'(DATA_MIN)) begin
			r.sat = 1'b1;
			r.val = DATA_MIN;
		end
		return r;
	endfunction

endpackage

### rtl/core/hpt_div_lane.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module hpt_div_lane import hpt_pkg::*; (
	input  logic              clk,
	input  logic [NUM_W-1:0]  num_mag,
	input  logic [DATA_W-1:0] den_mag,
	output logic [NUM_W-1:0]  q_mag
);

	logic [DATA_W-1:0] rem_c [0:DIV_STAGES];
	logic [NUM_W-1:0]  dq_c  [0:DIV_STAGES];
	logic [DATA_W-1:0] den_c [0:DIV_STAGES];

	assign rem_c[0] = '0;
	assign dq_c[0]  = num_mag;
	assign den_c[0] = den_mag;

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			logic [DATA_W:0]   tr;
			logic [DATA_W:0]   diff;
			logic              ge;
			logic [DATA_W-1:0] rem_s;
			logic [NUM_W-1:0]  dq_s;
			logic [DATA_W-1:0] den_s;

			assign tr   = {rem_c[k], dq_c[k][NUM_W-1]};
			assign diff = tr - {1'b0, den_c[k]};
			assign ge   = tr >= {1'b0, den_c[k]};

			always_ff @(posedge clk) begin
				rem_s <= ge ? diff[DATA_W-1:0] : tr[DATA_W-1:0];
				dq_s  <= {dq_c[k][NUM_W-2:0], ge};
				den_s <= den_c[k];
			end

			assign rem_c[k+1] = rem_s;
			assign dq_c[k+1]  = dq_s;
			assign den_c[k+1] = den_s;
		end
	endgenerate

	assign q_mag = dq_c[DIV_STAGES];

endmodule

### rtl/core/homogeneous_point_transform_top.sv
// Transforms one Q16.16 point or direction per clock by a 4x4 matrix held in
// eight 64-bit registers. A point (kind 0) gets translation and a divide by w
// when w is nonzero; a direction (kind 1) uses the upper 3x3 part only. A new
// item may be started every cycle (busy stays low); its result appears on
// result with result_valid high for one cycle once the start transfer has
// passed one multiply stage, one sum and clamp stage, one magnitude stage,
// 48 stages of the one-bit-per-stage divider, and the output register.
// The receiver cannot stall the block, so results must be taken as they come.
// The matrix resets to identity and should only be written while no item is
// in flight.
module homogeneous_point_transform_top import hpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hpt_in_t              cmd,
	output logic                 result_valid,
	output hpt_out_t             result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	logic [REG_W-1:0] mat_q [0:NUM_REGS-1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[REG_ROW0_C01[2:0]] <= ONE_LO;
			mat_q[REG_ROW0_C23[2:0]] <= '0;
			mat_q[REG_ROW1_C01[2:0]] <= ONE_HI;
			mat_q[REG_ROW1_C23[2:0]] <= '0;
			mat_q[REG_ROW2_C01[2:0]] <= '0;
			mat_q[REG_ROW2_C23[2:0]] <= ONE_LO;
			mat_q[REG_ROW3_C01[2:0]] <= '0;
			mat_q[REG_ROW3_C23[2:0]] <= ONE_HI;
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			mat_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// stage 1: twelve products and the translation column
	logic signed [DATA_W-1:0] pin [0:2];
	logic signed [PROD_W-1:0] prod_s1 [0:3][0:2];
	logic signed [DATA_W-1:0] t_s1 [0:3];
	logic                     point_s1;
	logic                     vld_s1;
	logic                     in_go;

	assign in_go  = start && !busy;
	assign pin[0] = cmd.in_x;
	assign pin[1] = cmd.in_y;
	assign pin[2] = cmd.in_z;

	genvar r, c;
	generate
		for (r = 0; r < 4; r++) begin : g_row
			for (c = 0; c < 3; c++) begin : g_col
				logic signed [DATA_W-1:0] m;
				assign m = mat_q[r*2 + c/2][(c%2)*32 +: DATA_W];
				always_ff @(posedge clk) begin
					prod_s1[r][c] <= PROD_W'(m) * PROD_W'(pin[c]);
				end
			end
			always_ff @(posedge clk) begin
				t_s1[r] <= cmd.kind ? '0 : mat_q[r*2 + 1][32 +: DATA_W];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		point_s1 <= !cmd.kind;
	end

	// stage 2: exact sum, floor by the fraction width, clamp
	hpt_clamp_t               row_cl [0:3];
	logic signed [DATA_W-1:0] v_s2 [0:3];
	logic                     sat_s2;
	logic                     point_s2;
	logic                     vld_s2;

	generate
		for (r = 0; r < 4; r++) begin : g_sum
			logic signed [SUM_W-1:0] sum;
			assign sum = SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
				+ SUM_W'(prod_s1[r][2]) + (SUM_W'(t_s1[r]) <<< FRAC_W);
			assign row_cl[r] = clamp_floor(FLOOR_W'(sum >>> FRAC_W));
			always_ff @(posedge clk) begin
				v_s2[r] <= row_cl[r].val;
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		// w is not used for directions, so its clamp does not count
		sat_s2   <= row_cl[0].sat | row_cl[1].sat | row_cl[2].sat
			| (point_s1 & row_cl[3].sat);
		point_s2 <= point_s1;
	end

	// stage 3: magnitudes and quotient signs into the divider lanes
	logic [NUM_W-1:0]  num_s3 [0:2];
	logic [DATA_W-1:0] den_s3;
	hpt_side_t         side_s3;
	logic              vld_s3;

	generate
		for (r = 0; r < 3; r++) begin : g_mag
			logic [DATA_W-1:0] vmag;
			assign vmag = v_s2[r][DATA_W-1] ? DATA_W'(-v_s2[r]) : DATA_W'(v_s2[r]);
			always_ff @(posedge clk) begin
				num_s3[r] <= {vmag, {FRAC_W{1'b0}}};
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		den_s3         <= v_s2[3][DATA_W-1] ? DATA_W'(-v_s2[3]) : DATA_W'(v_s2[3]);
		side_s3.do_div <= point_s2 && (v_s2[3] != '0);
		side_s3.sat    <= sat_s2;
		side_s3.qneg   <= {v_s2[2][DATA_W-1] ^ v_s2[3][DATA_W-1],
			v_s2[1][DATA_W-1] ^ v_s2[3][DATA_W-1],
			v_s2[0][DATA_W-1] ^ v_s2[3][DATA_W-1]};
		side_s3.vx     <= v_s2[0];
		side_s3.vy     <= v_s2[1];
		side_s3.vz     <= v_s2[2];
	end

	logic [NUM_W-1:0] q_mag [0:2];

	generate
		for (r = 0; r < 3; r++) begin : g_div
			hpt_div_lane u_lane (
				.clk     (clk),
				.num_mag (num_s3[r]),
				.den_mag (den_s3),
				.q_mag   (q_mag[r])
			);
		end
	endgenerate

	hpt_side_t             side_s4 [0:DIV_STAGES-1];
	logic [DIV_STAGES-1:0] vld_s4;

	always_ff @(posedge clk) begin
		side_s4[0] <= side_s3;
		for (int k = 1; k < DIV_STAGES; k++) begin
			side_s4[k] <= side_s4[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= '0;
		end else begin
			vld_s1 <= in_go;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= {vld_s4[DIV_STAGES-2:0], vld_s3};
		end
	end

	// output stage: sign the quotients and clamp, or pass the undivided values
	hpt_side_t                side_end;
	logic signed [DATA_W-1:0] qv [0:2];
	logic [2:0]               qsat;

	assign side_end = side_s4[DIV_STAGES-1];

	generate
		for (r = 0; r < 3; r++) begin : g_q
			always_comb begin
				qsat[r] = 1'b0;
				if (side_end.qneg[r]) begin
					qv[r] = -DATA_W'(q_mag[r][DATA_W-1:0]);
					if (q_mag[r] > (NUM_W'(1) << (DATA_W - 1))) begin
						qsat[r] = 1'b1;
						qv[r]   = DATA_MIN;
					end
				end else begin
					qv[r] = q_mag[r][DATA_W-1:0];
					if (q_mag[r] > NUM_W'(DATA_MAX)) begin
						qsat[r] = 1'b1;
						qv[r]   = DATA_MAX;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (side_end.do_div) begin
			result.out_x <= qv[0];
			result.out_y <= qv[1];
			result.out_z <= qv[2];
		end else begin
			result.out_x <= side_end.vx;
			result.out_y <= side_end.vy;
			result.out_z <= side_end.vz;
		end
		result.divided   <= side_end.do_div;
		result.saturated <= side_end.sat | (side_end.do_div & (|qsat));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s4[DIV_STAGES-1];
		end
	end

	// a direction never reaches the divide (a zero w is kept out by do_div too)
	a_dir_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !point_s2 |=> !side_s3.do_div)
		else $error("direction item marked for divide");

	a_undivided_pass: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4[DIV_STAGES-1] && !side_end.do_div |=>
		result.out_x == $past(side_end.vx) && !result.divided)
		else $error("undivided result differs from clamped sum");

	a_quot_sat_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4[DIV_STAGES-1] && !side_end.do_div && !side_end.sat |=>
		!result.saturated)
		else $error("saturation flagged without clamp");

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4[DIV_STAGES-1] |=> result_valid)
		else $error("result transfer lost");

endmodule
